FILE: hw/rtl/lrusp_pkg.sv
// Shared constants and types for the LRU stack page replacement block.
`default_nettype none

package lrusp_pkg;

  localparam int PAGE_W        = 16;
  localparam int CFG_W         = 4;
  localparam int SLOT_W        = 3;
  localparam int COUNT_W       = 32;
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // per-cell update controls, driven by the top level
  typedef struct packed {
    logic upd;     // reference word accepted this cycle
    logic hit;     // reference is resident
    logic full;    // all managed frames in use
    logic live;    // cell holds a resident entry
    logic lt_top;  // cell sits below the top of the stack
    logic at_top;  // cell is the current top of the stack
    logic at_fill; // cell is the first empty slot
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrusp_cell.sv
// One recency stack cell: holds a page and its frame, compares and shifts down.
`default_nettype none

module lrusp_cell #(
  parameter int PW = lrusp_pkg::PAGE_BITS_DEF,
  parameter int FW = 3
) (
  input  logic                  clk,
  input  lrusp_pkg::cell_ctl_t  ctl,
  input  logic [PW-1:0]         pg,
  input  logic [FW-1:0]         new_frame,
  input  logic [PW-1:0]         nb_page,
  input  logic [FW-1:0]         nb_frame,
  input  logic                  seen_in,
  output logic                  match,
  output logic                  seen_out,
  output logic [PW-1:0]         page,
  output logic [FW-1:0]         frame
);

  logic take_nb;
  logic load_new;

  assign match    = ctl.live && (page == pg);
  assign seen_out = seen_in || match;

  // on a hit the cells from the hit entry upward close the gap
  assign take_nb  = ctl.upd && ctl.lt_top && (ctl.hit ? seen_out : ctl.full);
  assign load_new = ctl.upd && ((ctl.hit || ctl.full) ? ctl.at_top : ctl.at_fill);

  always_ff @(posedge clk) begin
    if (take_nb) begin
      page  <= nb_page;
      frame <= nb_frame;
    end else if (load_new) begin
      page  <= pg;
      frame <= new_frame;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_stack_page_replacement.sv
// Top level of the LRU stack page replacement block.
`default_nettype none

// Tracks up to FRAMES resident pages in a row of stack cells, least recently
// used at cell 0. Each cell compares its page with the reference in parallel
// and shifts toward the bottom, so one reference word is taken every cycle
// and its result word appears in the output register on the next cycle; the
// input stalls only while that register holds a word that is not taken.
// Writing frames_in_use (0 reads as 1, values above FRAMES as FRAMES) empties
// all frames at once and keeps the fault count.
module lru_stack_page_replacement #(
  parameter int FRAMES    = lrusp_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrusp_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lrusp_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrusp_pkg::PAGE_W-1:0]     page,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             fault,
  output logic                             evicted,
  output logic [lrusp_pkg::PAGE_W-1:0]     victim_page,
  output logic [lrusp_pkg::SLOT_W-1:0]     frame_slot,
  output logic [lrusp_pkg::COUNT_W-1:0]    fault_total
);

  localparam int KB = (PAGE_BITS < lrusp_pkg::PAGE_W) ? PAGE_BITS : lrusp_pkg::PAGE_W;
  localparam int FB = $clog2(FRAMES + 1);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [lrusp_pkg::CFG_W-1:0]   frames_in_use;
  logic [FB-1:0]                 fill;
  logic [FB-1:0]                 fill_next;
  logic [lrusp_pkg::COUNT_W-1:0] fault_count;
  logic [lrusp_pkg::COUNT_W-1:0] fault_count_next;

  logic [FB-1:0]        n_act;
  logic [KB-1:0]        pg;
  logic                 upd;
  logic                 any_hit;
  logic                 full;
  logic [FW-1:0]        hit_frame;
  logic [FW-1:0]        new_frame;

  logic [FRAMES-1:0]    match;
  logic [FRAMES:0]      seen;
  logic [KB-1:0]        cell_page  [FRAMES];
  logic [FW-1:0]        cell_frame [FRAMES];
  lrusp_pkg::cell_ctl_t ctl        [FRAMES];

  always_comb begin
    if (frames_in_use == '0) begin
      n_act = FB'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_act = FB'(FRAMES);
    end else begin
      n_act = FB'(frames_in_use);
    end
  end

  assign pg       = page[KB-1:0];
  assign in_ready = !out_valid || out_ready;
  assign upd      = in_valid && in_ready;
  assign any_hit  = |match;
  assign full     = (fill >= n_act);
  assign seen[0]  = 1'b0;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_frame = hit_frame | (match[i] ? cell_frame[i] : '0);
    end
  end

  always_comb begin
    if (any_hit) begin
      new_frame = hit_frame;
    end else if (full) begin
      new_frame = cell_frame[0];
    end else begin
      new_frame = FW'(fill);
    end
  end

  generate
    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      assign ctl[i].upd     = upd && !cfg_wr_en;
      assign ctl[i].hit     = any_hit;
      assign ctl[i].full    = full;
      assign ctl[i].live    = (FB'(i) < fill);
      assign ctl[i].lt_top  = (FB'(i + 1) < fill);
      assign ctl[i].at_top  = (FB'(i + 1) == fill);
      assign ctl[i].at_fill = (FB'(i) == fill);

      if (i == FRAMES - 1) begin : g_last
        lrusp_cell #(.PW(KB), .FW(FW)) u_cell (
          .clk       (clk),
          .ctl       (ctl[i]),
          .pg        (pg),
          .new_frame (new_frame),
          .nb_page   (cell_page[i]),
          .nb_frame  (cell_frame[i]),
          .seen_in   (seen[i]),
          .match     (match[i]),
          .seen_out  (seen[i+1]),
          .page      (cell_page[i]),
          .frame     (cell_frame[i])
        );
      end else begin : g_mid
        lrusp_cell #(.PW(KB), .FW(FW)) u_cell (
          .clk       (clk),
          .ctl       (ctl[i]),
          .pg        (pg),
          .new_frame (new_frame),
          .nb_page   (cell_page[i+1]),
          .nb_frame  (cell_frame[i+1]),
          .seen_in   (seen[i]),
          .match     (match[i]),
          .seen_out  (seen[i+1]),
          .page      (cell_page[i]),
          .frame     (cell_frame[i])
        );
      end
    end
  endgenerate

  always_comb begin
    fill_next        = fill;
    fault_count_next = fault_count;
    if (cfg_wr_en) begin
      fill_next = '0;
    end else if (upd && !any_hit) begin
      if (!full) begin
        fill_next = fill + FB'(1);
      end
      if (fault_count != lrusp_pkg::COUNT_MAX) begin
        fault_count_next = fault_count + lrusp_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrusp_pkg::CFG_RESET;
      fill          <= '0;
      fault_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      fill        <= fill_next;
      fault_count <= fault_count_next;
      if (upd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      hit         <= any_hit;
      fault       <= !any_hit;
      evicted     <= !any_hit && full;
      victim_page <= (!any_hit && full) ? lrusp_pkg::PAGE_W'(cell_page[0]) : '0;
      frame_slot  <= lrusp_pkg::SLOT_W'(new_frame);
      fault_total <= fault_count_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= n_act) else $error("stack fill exceeds managed frames");

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match)) else $error("page resident in more than one cell");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    upd |=> out_valid) else $error("accepted word produced no result");

  a_full_fill_kept: assert property (@(posedge clk) disable iff (rst)
    (upd && !any_hit && full && !cfg_wr_en) |=> fill == $past(fill))
    else $error("eviction changed stack fill");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fault_count >= $past(fault_count))
    else $error("fault count decreased");
`endif

endmodule

`default_nettype wire
